@@ rtl/box_frustum_visibility_test_top_macros.svh @@
// assertion helpers for the frustum culling block
`ifndef BOX_FRUSTUM_VISIBILITY_TEST_TOP_MACROS_SVH
`define BOX_FRUSTUM_VISIBILITY_TEST_TOP_MACROS_SVH

// property a implies property b on the same edge
`define ASSERT_IMPL(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");

// property a implies b at the next edge
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");

`endif

@@ rtl/bfv_pkg.sv @@
`default_nettype none
package bfv_pkg;
	localparam int NumCfg = 6;
	localparam int NumMat = 16;
	localparam int DepthVisible = 3;
	localparam int NumPlanes = 6;
	localparam int CfgIdxW = 3;

	// command codes
	localparam logic CmdLoad = 1'b0;
	localparam logic CmdTest = 1'b1;

	// register indexes
	localparam logic [CfgIdxW-1:0] RegLowX  = 3'd0;
	localparam logic [CfgIdxW-1:0] RegHighZ = 3'd5;

	// per-stage control that travels with the item
	typedef struct packed {
		logic valid;
		logic trivial;
	} ctl_t;
endpackage
`default_nettype wire

@@ rtl/bfv_plane.sv @@
`default_nettype none
// one plane check: p-vertex pick, three products, sum, sign; three register stages
module bfv_plane
	import bfv_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic signed [32:0] px,
	input  wire logic signed [32:0] py,
	input  wire logic signed [32:0] pz,
	input  wire logic signed [32:0] pw,
	input  wire logic signed [34:0] lo_x,
	input  wire logic signed [34:0] lo_y,
	input  wire logic signed [34:0] lo_z,
	input  wire logic signed [34:0] hi_x,
	input  wire logic signed [34:0] hi_y,
	input  wire logic signed [34:0] hi_z,
	output logic                    reject
);
	logic signed [67:0] mx_s1, my_s1, mz_s1;
	logic signed [40:0] w_s1;
	logic signed [69:0] sxy_s2, sz_s2;
	logic signed [34:0] cx, cy, cz;

	always_comb begin
		cx = (px > 0) ? hi_x : lo_x;
		cy = (py > 0) ? hi_y : lo_y;
		cz = (pz > 0) ? hi_z : lo_z;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s1  <= px * cx;
			my_s1  <= py * cy;
			mz_s1  <= pz * cz;
			w_s1   <= {pw, 8'd0};
			sxy_s2 <= 70'(mx_s1) + 70'(my_s1);
			sz_s2  <= 70'(mz_s1) + 70'(w_s1);
			reject <= ((sxy_s2 + sz_s2) < 0);
		end
	end
endmodule
`default_nettype wire

@@ rtl/box_frustum_visibility_test_top.sv @@
// six register stages, s1 to s6; a result is valid when its item reaches s6
// throughput: one item per cycle; the pipeline advances whenever its last stage is empty or taken
// load items pass down the pipe as bubbles and produce no result
// a load writes the matrix when it leaves stage 3, where later tests read the planes
// reset clears the matrix, frame registers and all valid bits
`default_nettype none
`include "box_frustum_visibility_test_top_macros.svh"
module box_frustum_visibility_test_top
	import bfv_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic                cmd,
	input  wire logic [3:0]          matrix_index,
	input  wire logic signed [31:0]  matrix_value,
	input  wire logic [5:0]          tile_depth,
	input  wire logic signed [31:0]  box_low_x,
	input  wire logic signed [31:0]  box_low_y,
	input  wire logic signed [31:0]  box_low_z,
	input  wire logic signed [31:0]  box_high_x,
	input  wire logic signed [31:0]  box_high_y,
	input  wire logic signed [31:0]  box_high_z,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic signed [31:0]  cfg_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic                     visible
);
	logic signed [31:0] mat_q [NumMat];
	logic signed [31:0] frame_q [NumCfg];
	ctl_t c_s1, c_s2, c_s3, c_s4, c_s5, c_s6;
	logic ld_s1, ld_s2, ld_s3;
	logic [3:0] ldi_s1, ldi_s2, ldi_s3;
	logic signed [31:0] ldv_s1, ldv_s2, ldv_s3;
	logic en;
	logic signed [31:0] bl_s1 [3];
	logic signed [31:0] bh_s1 [3];
	logic signed [32:0] span_s1 [3];
	logic signed [31:0] flo_s1 [3];
	logic signed [64:0] tl_s2 [3];
	logic signed [64:0] th_s2 [3];
	logic signed [31:0] flo_s2 [3];
	logic signed [34:0] bxl_s3 [3];
	logic signed [34:0] bxh_s3 [3];
	logic signed [32:0] pl [NumPlanes][4];
	logic [NumPlanes-1:0] rej;

	assign en        = !c_s6.valid || out_ready;
	assign in_ready  = en;
	assign cfg_ready = 1'b1;
	assign out_valid = c_s6.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumMat; i++) mat_q[i] <= '0;
			for (int i = 0; i < NumCfg; i++) frame_q[i] <= '0;
		end else begin
			if (en && ld_s3) mat_q[ldi_s3] <= ldv_s3;
			if (cfg_valid && cfg_index <= RegHighZ) frame_q[cfg_index] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_s1 <= '0; c_s2 <= '0; c_s3 <= '0; c_s4 <= '0; c_s5 <= '0; c_s6 <= '0;
			ld_s1 <= 1'b0; ld_s2 <= 1'b0; ld_s3 <= 1'b0;
		end else if (en) begin
			c_s1.valid   <= in_valid && cmd == CmdTest;
			c_s1.trivial <= tile_depth < 6'(DepthVisible) ||
				(box_low_x == box_high_x && box_low_y == box_high_y
				 && box_low_z == box_high_z);
			c_s2 <= c_s1; c_s3 <= c_s2; c_s4 <= c_s3; c_s5 <= c_s4; c_s6 <= c_s5;
			ld_s1 <= in_valid && cmd == CmdLoad;
			ld_s2 <= ld_s1; ld_s3 <= ld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ldi_s1 <= matrix_index; ldi_s2 <= ldi_s1; ldi_s3 <= ldi_s2;
			ldv_s1 <= matrix_value; ldv_s2 <= ldv_s1; ldv_s3 <= ldv_s2;
			bl_s1[0] <= box_low_x;  bl_s1[1] <= box_low_y;  bl_s1[2] <= box_low_z;
			bh_s1[0] <= box_high_x; bh_s1[1] <= box_high_y; bh_s1[2] <= box_high_z;
			for (int a = 0; a < 3; a++) begin
				span_s1[a] <= 33'(frame_q[a+3]) - 33'(frame_q[a]);
				flo_s1[a]  <= frame_q[a + int'(RegLowX)];
				tl_s2[a]   <= bl_s1[a] * span_s1[a];
				th_s2[a]   <= bh_s1[a] * span_s1[a];
				flo_s2[a]  <= flo_s1[a];
				// arithmetic shift floors toward minus infinity
				bxl_s3[a]  <= 35'(tl_s2[a] >>> 30) + 35'(flo_s2[a]);
				bxh_s3[a]  <= 35'(th_s2[a] >>> 30) + 35'(flo_s2[a]);
			end
		end
	end

	always_comb begin
		for (int p = 0; p < NumPlanes; p++)
			for (int r = 0; r < 4; r++)
				pl[p][r] = (p % 2 == 1)
					? 33'(mat_q[12+r]) - 33'(mat_q[(p/2)*4+r])
					: 33'(mat_q[12+r]) + 33'(mat_q[(p/2)*4+r]);
	end

	for (genvar p = 0; p < NumPlanes; p++) begin : g_plane
		bfv_plane u_plane (
			.clk(clk), .en(en),
			.px(pl[p][0]), .py(pl[p][1]), .pz(pl[p][2]), .pw(pl[p][3]),
			.lo_x(bxl_s3[0]), .lo_y(bxl_s3[1]), .lo_z(bxl_s3[2]),
			.hi_x(bxh_s3[0]), .hi_y(bxh_s3[1]), .hi_z(bxh_s3[2]),
			.reject(rej[p])
		);
	end

	assign visible = c_s6.trivial || (rej == '0);

	`ASSERT_IMPL(a_stall_hold, clk, arst_n, out_valid && !out_ready, !in_ready)
	`ASSERT_NEXT(a_out_keep, clk, arst_n, out_valid && !out_ready, out_valid && $stable(visible))
	`ASSERT_NEXT(a_load_bubble, clk, arst_n, in_valid && in_ready && cmd == CmdLoad, !c_s1.valid)
endmodule
`default_nettype wire

@@ tb/sv/tb_box_frustum_visibility_test_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tb_box_frustum_visibility_test_top;
	import bfv_pkg::*;

	localparam int StallLimit = 4000;
	localparam int DrainCycles = 20;

	typedef struct {
		logic        cmd;
		logic [3:0]  idx;
		logic [31:0] value;
		logic [5:0]  depth;
		logic [31:0] lo [3];
		logic [31:0] hi [3];
	} tile_item_t;

	class cull_scoreboard;
		logic [31:0] matrix [NumMat];
		logic [31:0] frame [NumCfg];
		bit visible_q [$];
		int n_tests, n_hidden;

		function new();
			foreach (matrix[i]) matrix[i] = '0;
			foreach (frame[i]) frame[i] = '0;
		endfunction

		function void set_frame(int unsigned index, logic [31:0] data);
			if (index < NumCfg) frame[index] = data;
		endfunction

		function bit tile_visible(tile_item_t it);
			longint box [2][3];
			longint plane [4];
			longint lo_ext, span;
			logic signed [127:0] s, pa, ca;
			int col;
			if (it.depth < DepthVisible) return 1'b1;
			if (it.lo[0] == it.hi[0] && it.lo[1] == it.hi[1] && it.lo[2] == it.hi[2])
				return 1'b1;
			for (int a = 0; a < 3; a++) begin
				lo_ext = longint'($signed(frame[a]));
				span = longint'($signed(frame[a + 3])) - lo_ext;
				// arithmetic shift of the exact product floors toward minus infinity
				box[0][a] = ((longint'($signed(it.lo[a])) * span) >>> 30) + lo_ext;
				box[1][a] = ((longint'($signed(it.hi[a])) * span) >>> 30) + lo_ext;
			end
			for (int p = 0; p < NumPlanes; p++) begin
				col = p / 2;
				for (int r = 0; r < 4; r++)
					plane[r] = (p % 2) ?
						longint'($signed(matrix[12 + r])) - longint'($signed(matrix[col * 4 + r])) :
						longint'($signed(matrix[12 + r])) + longint'($signed(matrix[col * 4 + r]));
				s = plane[3];
				s = s * 256;
				for (int a = 0; a < 3; a++) begin
					pa = plane[a];
					ca = box[plane[a] > 0 ? 1 : 0][a];
					s = s + pa * ca;
				end
				if (s[127]) return 1'b0;
			end
			return 1'b1;
		endfunction

		function void note_input(tile_item_t it);
			bit v;
			if (it.cmd == CmdLoad) begin
				matrix[it.idx] = it.value;
			end else begin
				v = tile_visible(it);
				visible_q = {visible_q, v};
				n_tests++;
				if (!v) n_hidden++;
			end
		endfunction

		// returns 0 on a match, 1 on a wrong value, 2 when nothing was expected
		function int check_result(logic got);
			bit exp_v;
			if (visible_q.size() == 0) return 2;
			exp_v = visible_q.pop_front();
			return (got === exp_v) ? 0 : 1;
		endfunction
	endclass

	logic clk, arst_n;
	logic in_valid, in_ready, cmd;
	logic [3:0] matrix_index;
	logic signed [31:0] matrix_value;
	logic [5:0] tile_depth;
	logic signed [31:0] box_low_x, box_low_y, box_low_z;
	logic signed [31:0] box_high_x, box_high_y, box_high_z;
	logic cfg_valid, cfg_ready;
	logic [CfgIdxW-1:0] cfg_index;
	logic signed [31:0] cfg_data;
	logic out_valid, out_ready, visible;

	box_frustum_visibility_test_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .cmd(cmd),
		.matrix_index(matrix_index), .matrix_value(matrix_value), .tile_depth(tile_depth),
		.box_low_x(box_low_x), .box_low_y(box_low_y), .box_low_z(box_low_z),
		.box_high_x(box_high_x), .box_high_y(box_high_y), .box_high_z(box_high_z),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.out_valid(out_valid), .out_ready(out_ready), .visible(visible)
	);

	cull_scoreboard sb = new();
	int errors = 0;
	int sender_idle = 0, receiver_idle = 0;
	int quiet_cycles = 0;
	int n_results = 0;

	always begin
		clk = 1'b1; #1;
		clk = 1'b0; #1;
	end

	task automatic report(string what);
		$display("[%0t] mismatch: %s", $time, what);
		errors++;
	endtask

	// receiver side, result check and watchdog
	always @(posedge clk) begin
		int r;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				n_results++;
				r = sb.check_result(visible);
				if (r == 2) report($sformatf("unexpected result visible=%0b", visible));
				else if (r == 1) report($sformatf("visible=%0b, wrong value", visible));
			end
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= StallLimit) begin
				$display("timeout after %0d quiet cycles", quiet_cycles);
				$display("Mismatches found");
				$finish;
			end
		end
		out_ready <= ($urandom_range(99) >= receiver_idle);
	end

	task automatic send_item(tile_item_t it);
		while ($urandom_range(99) < sender_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= it.cmd;
		matrix_index <= it.idx;
		matrix_value <= it.value;
		tile_depth <= it.depth;
		box_low_x <= it.lo[0]; box_low_y <= it.lo[1]; box_low_z <= it.lo[2];
		box_high_x <= it.hi[0]; box_high_y <= it.hi[1]; box_high_z <= it.hi[2];
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_input(it);
	endtask

	task automatic write_reg(logic [CfgIdxW-1:0] index, logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_frame(index, data);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.visible_q.size() != 0) @(posedge clk);
		// load items may still be in flight
		repeat (DrainCycles) @(posedge clk);
	endtask

	function automatic logic [31:0] pick32();
		case ($urandom_range(9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return '0;
			3: return 32'hffff_ffff;
			4, 5: return $urandom_range(32'h8000_0000) - 32'h4000_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic tile_item_t load_item(logic [3:0] idx, logic [31:0] value);
		tile_item_t it;
		it.cmd = CmdLoad; it.idx = idx; it.value = value; it.depth = 6'($urandom);
		for (int a = 0; a < 3; a++) begin
			it.lo[a] = $urandom; it.hi[a] = $urandom;
		end
		return it;
	endfunction

	function automatic tile_item_t test_item(logic [5:0] depth, bit extreme);
		tile_item_t it;
		it.cmd = CmdTest; it.idx = 4'($urandom); it.value = $urandom; it.depth = depth;
		for (int a = 0; a < 3; a++) begin
			// normalized corners mostly inside [0, 1] in Q2.30
			it.lo[a] = extreme ? pick32() : $urandom_range(32'h3000_0000);
			it.hi[a] = extreme ? pick32() : it.lo[a] + $urandom_range(32'h1000_0000);
		end
		if ($urandom_range(19) == 0) it.hi = it.lo;
		return it;
	endfunction

	task automatic set_frame_regs(int setting);
		logic [31:0] v;
		for (int i = 0; i < NumCfg; i++) begin
			case (setting)
				0: v = (i < 3) ? 32'hffff_9c00 : 32'h0000_6400;
				1: v = (i < 3) ? 32'h8000_0000 : 32'h7fff_ffff;
				2: v = (i < 3) ? 32'h7fff_ffff : 32'h8000_0000;
				default: v = pick32();
			endcase
			write_reg(CfgIdxW'(int'(RegLowX) + i), v);
		end
		// indexes past the last register are ignored
		write_reg(CfgIdxW'(int'(RegHighZ) + 1), $urandom);
		write_reg(CfgIdxW'(int'(RegHighZ) + 2), $urandom);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		tile_item_t it;
		arst_n = 1'b0;
		in_valid <= 1'b0; cmd <= CmdLoad; matrix_index <= '0; matrix_value <= '0;
		tile_depth <= '0;
		box_low_x <= '0; box_low_y <= '0; box_low_z <= '0;
		box_high_x <= '0; box_high_y <= '0; box_high_z <= '0;
		cfg_valid <= 1'b0; cfg_index <= '0; cfg_data <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_frame_regs(0);
		// directed: all-zero matrix, depth and equal-corner shortcuts, extremes
		send_item(test_item(6'd3, 0));
		for (int i = 0; i < 16; i++)
			send_item(load_item(i[3:0], (i % 5 == 0) ? 32'h0100_0000 : 32'h0000_0000));
		send_item(test_item(6'd0, 1));
		send_item(test_item(6'd2, 1));
		send_item(test_item(6'd63, 1));
		it = test_item(6'd3, 1);
		it.lo = '{32'h8000_0000, 32'h7fff_ffff, 32'h0};
		it.hi = it.lo;
		send_item(it);
		it.hi = '{32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff};
		send_item(it);
		send_item(load_item(4'd15, 32'h8000_0000));
		send_item(load_item(4'd0, 32'h7fff_ffff));
		send_item(test_item(6'd40, 1));

		for (int phase = 0; phase < 3; phase++) begin
			sender_idle = (phase == 0) ? 33 : (phase == 1) ? 64 : 0;
			receiver_idle = (phase == 0) ? 64 : (phase == 1) ? 33 : 0;
			for (int setting = 0; setting < 2; setting++) begin
				wait_drained();
				set_frame_regs(phase == 2 ? 3 - setting : 3 * setting + phase % 2);
				for (int n = 0; n < 205; n++) begin
					if ($urandom_range(3) == 0)
						send_item(load_item(4'($urandom), $urandom_range(1) ? pick32() :
							$urandom_range(32'h0200_0000) - 32'h0100_0000));
					else
						send_item(test_item(6'($urandom), $urandom_range(4) == 0));
				end
			end
		end

		wait_drained();
		$display("covered %0d box tests (%0d culled) over several frame and matrix settings",
			sb.n_tests, sb.n_hidden);
		$display("%0d results checked under three idle patterns", n_results);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
`default_nettype wire
